// ===== hdl/itu_pkg.sv =====
// ----------------------------------------------------------------------------
// Interrupt trap unit package
// Field widths shared by the channel interfaces and the core, and the
// operation, register, fault and status codes and fault vector table of the core.
// ----------------------------------------------------------------------------
package itu_pkg;

    // Field widths
    localparam int OP_W      = 3;
    localparam int EXT_W     = 34;
    localparam int FAULT_W   = 5;
    localparam int ADDR_W    = 64;
    localparam int SEL_W     = 3;
    localparam int DATA_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int LEVEL_W   = 5;
    localparam int SOFT_W    = 19;
    localparam int ID_W      = 6;
    localparam int VEC_W     = 14;

    // Request bit ranges for the priority encoder
    localparam int SOFT_LEVEL_FIRST = 4;
    localparam int SOFT_LEVEL_END   = 19;
    localparam int EXT_LEVEL_FIRST  = 20;
    localparam int EXT_LEVEL_END    = 34;

    // Register write masks and the PALcall restart step
    localparam logic [SOFT_W-1:0] SOFT_MASK    = 19'h7fff0;
    localparam logic [DATA_W-1:0] RESTART_MASK = ~64'd2;
    localparam logic [ADDR_W-1:0] PALCALL_STEP = 64'd4;

    // Operations
    localparam logic [OP_W-1:0] OP_CHECK   = 3'd0;
    localparam logic [OP_W-1:0] OP_FAULT   = 3'd1;
    localparam logic [OP_W-1:0] OP_RETURN  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    // Register selects
    localparam logic [SEL_W-1:0] REG_LEVEL   = 3'd0;
    localparam logic [SEL_W-1:0] REG_SOFT    = 3'd1;
    localparam logic [SEL_W-1:0] REG_RESTART = 3'd2;
    localparam logic [SEL_W-1:0] REG_SUMMARY = 3'd3;
    localparam logic [SEL_W-1:0] REG_INT_ID  = 3'd4;

    // Fault numbers
    localparam logic [FAULT_W-1:0] FAULT_NONE    = 5'd0;
    localparam logic [FAULT_W-1:0] FAULT_ARITH   = 5'd3;
    localparam logic [FAULT_W-1:0] FAULT_INTR    = 5'd4;
    localparam logic [FAULT_W-1:0] FAULT_PALCALL = 5'd15;
    localparam logic [FAULT_W-1:0] FAULT_LAST    = 5'd16;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNIMP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ARITH = 2'd2;

    // Handler offset from the privileged base for each fault.
    function automatic logic [VEC_W-1:0] fault_vector(input logic [FAULT_W-1:0] code);
        logic [VEC_W-1:0] vec;
        case (code)
            5'd1:    vec = 14'h0001;
            5'd2:    vec = 14'h0401;
            5'd3:    vec = 14'h0501;
            5'd4:    vec = 14'h0101;
            5'd5:    vec = 14'h0201;
            5'd6:    vec = 14'h0281;
            5'd7:    vec = 14'h0301;
            5'd8:    vec = 14'h0381;
            5'd9:    vec = 14'h0381;
            5'd10:   vec = 14'h0181;
            5'd11:   vec = 14'h0181;
            5'd12:   vec = 14'h0081;
            5'd13:   vec = 14'h0481;
            5'd14:   vec = 14'h0581;
            5'd15:   vec = 14'h2001;
            5'd16:   vec = 14'h0501;
            default: vec = 14'h0000;
        endcase
        return vec;
    endfunction

endpackage

// ===== hdl/itu_req_if.sv =====
// ----------------------------------------------------------------------------
// Interrupt trap unit request channel
// Valid/ready channel that carries one operation item to the core.
// ----------------------------------------------------------------------------
interface itu_req_if;
    import itu_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [EXT_W-1:0]    ext_pending;
    logic [FAULT_W-1:0]  fault_code;
    logic [ADDR_W-1:0]   current_pc;
    logic [SEL_W-1:0]    reg_select;
    logic [DATA_W-1:0]   write_data;

    modport source (
        output valid, operation, ext_pending, fault_code, current_pc,
               reg_select, write_data,
        input  ready
    );

    modport sink (
        input  valid, operation, ext_pending, fault_code, current_pc,
               reg_select, write_data,
        output ready
    );
endinterface

// ===== hdl/itu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Interrupt trap unit result channel
// Valid/ready channel that carries one result item from the core.
// ----------------------------------------------------------------------------
interface itu_rsp_if;
    import itu_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                redirect;
    logic [ADDR_W-1:0]   next_pc;
    logic                interrupt_taken;
    logic [DATA_W-1:0]   read_data;

    modport source (
        output valid, status, redirect, next_pc, interrupt_taken, read_data,
        input  ready
    );

    modport sink (
        input  valid, status, redirect, next_pc, interrupt_taken, read_data,
        output ready
    );
endinterface

// ===== hdl/interrupt_trap_unit_core.sv =====
// ----------------------------------------------------------------------------
// Interrupt trap unit core
// Interrupt priority check, fault vectoring, trap return and control
// register access; each operation item passes through two registers.
// ----------------------------------------------------------------------------
// A result item passes through the input register, then the result register.
// Throughput: one item per cycle while the result channel does not stall;
// the control state is updated as an item moves between the two registers.
// Reset (synchronous, active low) empties both registers and clears the
// privileged base and all control registers to zero.
module interrupt_trap_unit_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [itu_pkg::ADDR_W-1:0] i_cfg_wdata,
    itu_req_if.sink                    i_req,
    itu_rsp_if.source                  o_rsp
);
    import itu_pkg::*;

    // Input register
    logic                r_in_valid;
    logic [OP_W-1:0]     r_in_op;
    logic [EXT_W-1:0]    r_in_ext;
    logic [FAULT_W-1:0]  r_in_fault;
    logic [ADDR_W-1:0]   r_in_pc;
    logic [SEL_W-1:0]    r_in_sel;
    logic [DATA_W-1:0]   r_in_wdata;

    // Control state
    logic [ADDR_W-1:0]   r_pal_base;
    logic [LEVEL_W-1:0]  r_ipl, n_ipl;
    logic [SOFT_W-1:0]   r_soft, n_soft;
    logic [ADDR_W-1:0]   r_restart, n_restart;
    logic [EXT_W-1:0]    r_summary, n_summary;
    logic [ID_W-1:0]     r_int_id, n_int_id;

    // Result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_redirect, n_redirect;
    logic [ADDR_W-1:0]   r_next_pc, n_next_pc;
    logic                r_taken, n_taken;
    logic [DATA_W-1:0]   r_read, n_read;

    logic                advance;
    logic                in_ready;
    logic [ID_W-1:0]     lvl;
    logic [EXT_W-1:0]    sum;
    logic                do_trap;
    logic [FAULT_W-1:0]  trap_code;
    logic                priv;

    assign advance  = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready = !r_in_valid || advance;
    assign priv     = r_in_pc[0];

    assign i_req.ready           = in_ready;
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.redirect        = r_redirect;
    assign o_rsp.next_pc         = r_next_pc;
    assign o_rsp.interrupt_taken = r_taken;
    assign o_rsp.read_data       = r_read;

    // Priority encoder: the highest pending bit wins, and external lines
    // rank above software requests.
    always_comb begin
        lvl = '0;
        sum = '0;
        for (int i = SOFT_LEVEL_FIRST; i < SOFT_LEVEL_END; i++) begin
            if (r_soft[i]) begin
                lvl    = ID_W'(i - SOFT_LEVEL_FIRST + 1);
                sum[i] = 1'b1;
            end
        end
        for (int i = EXT_LEVEL_FIRST; i < EXT_LEVEL_END; i++) begin
            if (r_in_ext[i]) begin
                lvl    = ID_W'(i);
                sum[i] = 1'b1;
            end
        end
    end

    always_comb begin
        n_status   = ST_OK;
        n_redirect = 1'b0;
        n_next_pc  = '0;
        n_taken    = 1'b0;
        n_read     = '0;
        n_ipl      = r_ipl;
        n_soft     = r_soft;
        n_restart  = r_restart;
        n_summary  = r_summary;
        n_int_id   = r_int_id;
        do_trap    = 1'b0;
        trap_code  = r_in_fault;

        case (r_in_op)
            OP_CHECK: begin
                if (lvl != '0 && lvl > {1'b0, r_ipl}) begin
                    n_summary = sum;
                    n_int_id  = lvl;
                    do_trap   = 1'b1;
                    trap_code = FAULT_INTR;
                    n_taken   = 1'b1;
                end
            end
            OP_FAULT: begin
                if (r_in_fault == FAULT_NONE) begin
                    n_status = ST_OK;
                end else if (r_in_fault > FAULT_LAST) begin
                    n_status = ST_UNIMP;
                end else if (r_in_fault == FAULT_ARITH) begin
                    n_status = ST_ARITH;
                end else begin
                    do_trap = 1'b1;
                end
            end
            OP_RETURN: begin
                if (!priv) begin
                    n_status = ST_UNIMP;
                end else begin
                    n_redirect = 1'b1;
                    n_next_pc  = r_restart;
                end
            end
            OP_WRITE: begin
                case (r_in_sel)
                    REG_LEVEL:   n_ipl     = r_in_wdata[LEVEL_W-1:0];
                    REG_SOFT:    n_soft    = r_in_wdata[SOFT_W-1:0] & SOFT_MASK;
                    REG_RESTART: n_restart = r_in_wdata & RESTART_MASK;
                    default:     n_status  = ST_UNIMP;
                endcase
            end
            OP_READ: begin
                case (r_in_sel)
                    REG_LEVEL:   n_read   = DATA_W'(r_ipl);
                    REG_SOFT:    n_read   = DATA_W'(r_soft);
                    REG_RESTART: n_read   = r_restart;
                    REG_SUMMARY: n_read   = DATA_W'(r_summary);
                    REG_INT_ID:  n_read   = DATA_W'(r_int_id);
                    default:     n_status = ST_UNIMP;
                endcase
            end
            default: n_status = ST_UNIMP;
        endcase

        // An interrupt taken in privileged mode keeps the old restart address.
        if (do_trap) begin
            if (trap_code != FAULT_INTR || !priv) begin
                n_restart = r_in_pc + ((trap_code == FAULT_PALCALL) ? PALCALL_STEP : '0);
            end
            n_redirect = 1'b1;
            n_next_pc  = r_pal_base + ADDR_W'(fault_vector(trap_code));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pal_base  <= '0;
            r_ipl       <= '0;
            r_soft      <= '0;
            r_restart   <= '0;
            r_summary   <= '0;
            r_int_id    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_pal_base <= i_cfg_wdata;
            end
            if (in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ipl       <= n_ipl;
                r_soft      <= n_soft;
                r_restart   <= n_restart;
                r_summary   <= n_summary;
                r_int_id    <= n_int_id;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_in_op    <= i_req.operation;
            r_in_ext   <= i_req.ext_pending;
            r_in_fault <= i_req.fault_code;
            r_in_pc    <= i_req.current_pc;
            r_in_sel   <= i_req.reg_select;
            r_in_wdata <= i_req.write_data;
        end
        if (advance) begin
            r_status   <= n_status;
            r_redirect <= n_redirect;
            r_next_pc  <= n_next_pc;
            r_taken    <= n_taken;
            r_read     <= n_read;
        end
    end

endmodule
